[hdl/rc_pwm_pulse_capture_defines.svh]
// Assertion macros for the checker file of the pulse capture block.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef RC_PWM_PULSE_CAPTURE_DEFINES_SVH
`define RC_PWM_PULSE_CAPTURE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RCPWM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rcpwm_pkg.sv]
// Shared types, constants and the pin-to-slot map of the pulse capture block.
// No dependencies.
package rcpwm_pkg;

	localparam int CHANNELS = 8;
	localparam int NUM_PINS = 8;
	localparam int PIN_W    = 3;
	localparam int TIME_W   = 16;

	localparam logic [TIME_W-1:0] RESET_MIN_WIDTH  = 16'd900;
	localparam logic [TIME_W-1:0] RESET_MAX_WIDTH  = 16'd2200;
	localparam logic [TIME_W-1:0] RESET_SLOT_WIDTH = 16'd1502;

	// Configuration register indexes
	localparam logic REG_MIN_WIDTH = 1'b0;
	localparam logic REG_MAX_WIDTH = 1'b1;

	// Function codes of an input beat
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef logic [TIME_W-1:0] width_t;
	typedef logic [PIN_W-1:0]  pin_idx_t;

	// What one lane found for the current sample
	typedef struct packed {
		logic   hit;
		width_t width;
	} lane_result_t;

	// Load request from the top level into the merge stage
	typedef struct packed {
		logic     load;
		logic     is_read;
		pin_idx_t read_slot;
		width_t   read_width;
	} merge_load_t;

	function automatic pin_idx_t pin_to_slot(input pin_idx_t pin);
		pin_idx_t s;
		case (pin)
			3'd0:    s = 3'd2;
			3'd1:    s = 3'd4;
			3'd2:    s = 3'd5;
			3'd3:    s = 3'd6;
			3'd4:    s = 3'd7;
			3'd5:    s = 3'd0;
			3'd6:    s = 3'd1;
			default: s = 3'd3;
		endcase
		return s;
	endfunction

endpackage

[hdl/rcpwm_if.sv]
// Valid/ready channel interfaces for sample beats and result beats.
// No dependencies.
interface rcpwm_smp_if;
	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [7:0]              port_pins;
	logic [15:0]             time_us;
	logic [2:0]              read_slot;

	modport source(output valid, func, port_pins, time_us, read_slot, input ready);
	modport sink(input valid, func, port_pins, time_us, read_slot, output ready);
endinterface

interface rcpwm_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  slot;
	logic [15:0] width;
	logic        is_read;
	logic        last;

	modport source(output valid, slot, width, is_read, last, input ready);
	modport sink(input valid, slot, width, is_read, last, output ready);
endinterface

[hdl/rcpwm_lane.sv]
// One capture lane: edge detect, rise time store, width and range check.
// Depends on rcpwm_pkg.
module rcpwm_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample,
	input  logic                  pin_now,
	input  logic                  pin_prev,
	input  rcpwm_pkg::width_t     time_us,
	input  rcpwm_pkg::width_t     min_width,
	input  rcpwm_pkg::width_t     max_width,
	output rcpwm_pkg::lane_result_t res
);
	import rcpwm_pkg::*;

	width_t rise_q;
	width_t w;
	logic   fall;

	// Record the time of a rising edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
		end else if (sample && pin_now && !pin_prev) begin
			rise_q <= time_us;
		end
	end

	// Width modulo 2^16 and strict range check on a falling edge
	assign fall      = pin_prev && !pin_now;
	assign w         = time_us - rise_q;
	assign res.width = w;
	assign res.hit   = sample && fall && (min_width < w) && (w < max_width);

endmodule

[hdl/rcpwm_merge.sv]
// Merge stage: holds what the lanes found and emits one beat per cycle in pin order while the result sink takes them.
// Depends on rcpwm_pkg and rcpwm_if.
module rcpwm_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rcpwm_pkg::merge_load_t          ld,
	input  rcpwm_pkg::lane_result_t [7:0]   lanes,
	output logic                            can_load,
	rcpwm_res_if.source                     res
);
	import rcpwm_pkg::*;

	logic [NUM_PINS-1:0] pend_q;
	width_t              widths_q [NUM_PINS];
	logic                rd_q;
	pin_idx_t            rslot_q;
	width_t              rwidth_q;

	logic                out_valid_q;
	pin_idx_t            out_slot_q;
	width_t              out_width_q;
	logic                out_is_read_q;
	logic                out_last_q;

	logic                busy;
	logic                adv;
	logic                final_beat;
	pin_idx_t            sel;
	logic [NUM_PINS-1:0] rest;

	// Find the lowest pending pin
	always_comb begin
		sel = '0;
		for (int p = NUM_PINS - 1; p >= 0; p--) begin
			if (pend_q[p]) sel = PIN_W'(p);
		end
	end

	assign rest       = pend_q & (pend_q - NUM_PINS'(1));
	assign busy       = rd_q || (pend_q != '0);
	assign adv        = busy && (!out_valid_q || res.ready);
	assign final_beat = rd_q || (rest == '0);
	assign can_load   = !busy || (adv && final_beat);

	// Hold the pending results of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			rd_q   <= 1'b0;
		end else if (ld.load) begin
			rd_q <= ld.is_read;
			for (int p = 0; p < NUM_PINS; p++) begin
				pend_q[p] <= !ld.is_read && lanes[p].hit;
			end
		end else if (adv) begin
			rd_q   <= 1'b0;
			pend_q <= rd_q ? pend_q : rest;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			rslot_q  <= ld.read_slot;
			rwidth_q <= ld.read_width;
			for (int p = 0; p < NUM_PINS; p++) begin
				widths_q[p] <= lanes[p].width;
			end
		end
	end

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rd_q) begin
				out_slot_q    <= rslot_q;
				out_width_q   <= rwidth_q;
				out_is_read_q <= 1'b1;
				out_last_q    <= 1'b1;
			end else begin
				out_slot_q    <= pin_to_slot(sel);
				out_width_q   <= widths_q[sel];
				out_is_read_q <= 1'b0;
				out_last_q    <= rest == '0;
			end
		end
	end

	assign res.valid   = out_valid_q;
	assign res.slot    = out_slot_q;
	assign res.width   = out_width_q;
	assign res.is_read = out_is_read_q;
	assign res.last    = out_last_q;

endmodule

[hdl/rc_pwm_pulse_capture.sv]
// Top level of the RC pulse width capture block: registers, lanes and merge stage.
// Depends on rcpwm_pkg, rcpwm_if, rcpwm_lane and rcpwm_merge.
//
//   channel | dir | handshake      | payload
//   smp     | in  | valid/ready    | func, port_pins, time_us, read_slot
//   res     | out | valid/ready    | slot, width, is_read, last
//   cfg     | in  | cfg_we only    | cfg_idx, cfg_data
//
// When a sample beat is taken, all lanes check their pin in parallel and the slot
// table is updated at that edge. The merge stage then emits one result beat per cycle
// while the result sink takes them: one per accepted pulse of a sample item (none if
// it has none) and one for a read; the next beat is taken in the cycle its last result
// moves to the output register. Reset is asynchronous and leaves the block ready at
// once. A stalled result sink holds the output register and, behind it, the input.
module rc_pwm_pulse_capture (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [15:0]       cfg_data,
	rcpwm_smp_if.sink         smp,
	rcpwm_res_if.source       res
);
	import rcpwm_pkg::*;

	width_t                      min_q;
	width_t                      max_q;
	logic [NUM_PINS-1:0]         prev_q;
	width_t                      slot_width_q [NUM_PINS];
	lane_result_t [NUM_PINS-1:0] lane_res;
	merge_load_t                 ld;
	logic                        can_load;
	logic                        accept;
	logic                        sample;

	assign smp.ready = can_load;
	assign accept    = smp.valid && can_load;
	assign sample    = accept && (smp.func == FUNC_SAMPLE);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= RESET_MIN_WIDTH;
			max_q <= RESET_MAX_WIDTH;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_WIDTH: min_q <= cfg_data;
				REG_MAX_WIDTH: max_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Store pin levels on every sample beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (sample) begin
			prev_q <= smp.port_pins;
		end
	end

	// Lanes for the pins in use; the rest never hit
	for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
		if (i < CHANNELS) begin : g_on
			rcpwm_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.sample    (sample),
				.pin_now   (smp.port_pins[i]),
				.pin_prev  (prev_q[i]),
				.time_us   (smp.time_us),
				.min_width (min_q),
				.max_width (max_q),
				.res       (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = '0;
		end
	end

	// Update slots of accepted pulses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_PINS; s++) begin
				slot_width_q[s] <= RESET_SLOT_WIDTH;
			end
		end else begin
			for (int p = 0; p < NUM_PINS; p++) begin
				if (lane_res[p].hit) begin
					slot_width_q[pin_to_slot(PIN_W'(p))] <= lane_res[p].width;
				end
			end
		end
	end

	assign ld.load       = accept;
	assign ld.is_read    = smp.func == FUNC_READ;
	assign ld.read_slot  = smp.read_slot;
	assign ld.read_width = slot_width_q[smp.read_slot];

	rcpwm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.lanes    (lane_res),
		.can_load (can_load),
		.res      (res)
	);

endmodule

[hdl/rcpwm_checker.sv]
// Port-level checks of the pulse capture block and the bind that attaches them.
// Depends on rc_pwm_pulse_capture_defines.svh and rc_pwm_pulse_capture.
`include "rc_pwm_pulse_capture_defines.svh"

module rcpwm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_is_read,
	input logic out_last
);

	// A result beat that waits stays offered
	`RCPWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

	// Input stalls only while a result waits or the item just taken starts draining
	`RCPWM_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid || $past(in_valid && in_ready), "input stalled with nothing pending")

	// A read answer is always the final beat of its item
	`RCPWM_ASSERT_IMPL(a_read_last, out_valid && out_is_read, out_last, "read answer without last")

endmodule

bind rc_pwm_pulse_capture rcpwm_checker u_rcpwm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (smp.valid),
	.in_ready    (smp.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_is_read (res.is_read),
	.out_last    (res.last)
);
